FILE: design/agpe_pkg.sv
// ============================================================================
// agpe_pkg: shared types, constants and functions of the group prefix encoder
// Holds the list geometry, field widths, the entry layout of the list memory
// and the functions that classify a difference and build codewords.
// ============================================================================
`default_nettype none

package agpe_pkg;

    // List geometry and field widths.
    localparam int NUM_GROUPS  = 8;
    localparam int RAW_BITS    = 16;
    localparam int WEIGHT_BITS = 16;

    localparam int POS_W   = $clog2(NUM_GROUPS);
    localparam int CNT_W   = $clog2(NUM_GROUPS + 1);
    localparam int GROUP_W = 3;
    localparam int MAG_W   = 7;
    localparam int DIFF_W  = 8;
    localparam int CODE_W  = 24;
    localparam int LEN_W   = 5;

    // One entry of the ordered list.
    typedef struct packed {
        logic [GROUP_W-1:0]     group_id;
        logic [WEIGHT_BITS-1:0] weight;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result item before it goes to the output register.
    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } result_t;

    // Sign flag of a difference.
    function automatic logic diff_neg(input logic [DIFF_W-1:0] diff);
        return diff[DIFF_W-1];
    endfunction

    // Magnitude of a difference; the most negative code saturates to 127.
    function automatic logic [MAG_W-1:0] diff_mag(input logic [DIFF_W-1:0] diff);
        logic [DIFF_W-1:0] abs_v;
        abs_v = diff[DIFF_W-1] ? DIFF_W'(~diff + 1'b1) : diff;
        return abs_v[DIFF_W-1] ? {MAG_W{1'b1}} : abs_v[MAG_W-1:0];
    endfunction

    // Group number: bit length of the magnitude.
    function automatic logic [GROUP_W-1:0] group_of(input logic [MAG_W-1:0] mag);
        logic [GROUP_W-1:0] k;
        k = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mag[i]) begin
                k = GROUP_W'(i + 1);
            end
        end
        return k;
    endfunction

    // Codeword of a group found at list position pos.
    function automatic result_t known_code(input logic [GROUP_W-1:0] k,
                                           input logic               neg,
                                           input logic [MAG_W-1:0]   mag,
                                           input logic [POS_W-1:0]   pos);
        logic [GROUP_W-1:0] klen;
        logic [MAG_W-1:0]   mask;
        logic [MAG_W-1:0]   suf;
        logic [MAG_W:0]     word;
        result_t            res;
        klen = (k == '0) ? GROUP_W'(1) : k;
        mask = MAG_W'((8'd1 << k) - 8'd1);
        if (k == '0) begin
            suf = MAG_W'(1);
        end else if (neg) begin
            suf = ~mag & mask;
        end else begin
            suf = mag;
        end
        word            = (8'd1 << klen) | {1'b0, suf};
        res.code_bits   = CODE_W'(word);
        res.code_length = LEN_W'(32'(pos) + 32'd1 + 32'(klen));
        return res;
    endfunction

    // Codeword of a group not yet in the list: leaf zeros, then sign-magnitude.
    function automatic result_t raw_code(input logic               neg,
                                         input logic [MAG_W-1:0]   mag,
                                         input logic [CNT_W-1:0]   leaf);
        logic [RAW_BITS-1:0] raw;
        result_t             res;
        raw = RAW_BITS'(mag);
        if (neg && (mag != '0)) begin
            raw[RAW_BITS-1] = 1'b1;
        end
        res.code_bits   = CODE_W'(raw);
        res.code_length = LEN_W'(32'(leaf) + 32'(RAW_BITS));
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/agpe_if.sv
// ============================================================================
// agpe_if: request channels of the group prefix encoder
// Sample channel carries one difference; code channel carries one codeword.
// ============================================================================
`default_nettype none

interface agpe_in_if import agpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIFF_W-1:0] diff;
    logic              last_sample;

    modport source (output valid, output diff, output last_sample, input ready);
    modport sink   (input valid, input diff, input last_sample, output ready);
endinterface

interface agpe_out_if import agpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last;

    modport source (output valid, output code_bits, output code_length, output last,
                    input ready);
    modport sink   (input valid, input code_bits, input code_length, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: design/agpe_ram.sv
// ============================================================================
// agpe_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module agpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/adaptive_group_prefix_encoder_top.sv
// ============================================================================
// adaptive_group_prefix_encoder_top: adaptive group prefix encoder
// Codes sample differences with a weight-ordered list of groups.
// ============================================================================
// Each request on the sample channel carries one difference in tenths. The
// block sorts it into a group (bit length of the magnitude) and looks the
// group up in an ordered list kept in a small synchronous RAM, heaviest
// entry first. A group found at position p yields p zeros, a one and the
// group suffix; its weight then goes up by one (saturating) and the entry
// moves toward the head past every strictly lighter entry, one swap per
// cycle. A group not yet listed yields one zero per listed group followed by
// a 16-bit sign-magnitude raw value, and is appended with weight one while
// the list has room. Exactly one code request follows each sample request,
// in order. The list RAM has one read port with registered read data, and
// the search reads one entry per cycle. An item found at position p passes
// acceptance, p + 1 search reads, up to p swaps, a final write of the moved
// entry and the hand-off to the output register; a new group passes
// acceptance, reads of all listed entries and the hand-off, the very first
// item only acceptance and hand-off. Only one item is in flight; the sample
// channel is ready again once the result sits in the output register, which
// holds it until the sink takes it. Reset clears, of the list, only its
// length; entries beyond it are never read, so the RAM needs no clearing pass.
// ============================================================================
`default_nettype none

module adaptive_group_prefix_encoder_top
    import agpe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    agpe_in_if.sink    sample,
    agpe_out_if.source code
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_BUBBLE,
        S_HEAD,
        S_OUT
    } state_t;

    // Control registers.
    state_t             state_reg,       state_next;
    logic [CNT_W-1:0]   leaf_count_reg,  leaf_count_next;
    logic               out_valid_reg,   out_valid_next;

    // Payload registers of the item in flight.
    logic [GROUP_W-1:0]     k_reg,       k_next;
    logic                   neg_reg,     neg_next;
    logic [MAG_W-1:0]       mag_reg,     mag_next;
    logic                   last_reg,    last_next;
    logic [POS_W-1:0]       pos_reg,     pos_next;
    logic [WEIGHT_BITS-1:0] weight_reg,  weight_next;
    result_t                res_reg,     res_next;

    // Output register.
    result_t                out_res_reg,  out_res_next;
    logic                   out_last_reg, out_last_next;

    // List RAM ports.
    logic             ram_we;
    logic [POS_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [POS_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    // Classification of the incoming sample.
    logic               in_neg;
    logic [MAG_W-1:0]   in_mag;
    logic [GROUP_W-1:0] in_k;
    logic               hit;
    logic [WEIGHT_BITS-1:0] hit_weight;
    logic               out_free;

    agpe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_GROUPS)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_neg = diff_neg(sample.diff);
    assign in_mag = diff_mag(sample.diff);
    assign in_k   = group_of(in_mag);

    // The entry read last cycle matches the group in flight.
    assign hit        = (ram_rdata.group_id == k_reg);
    assign hit_weight = (ram_rdata.weight == {WEIGHT_BITS{1'b1}}) ?
                        ram_rdata.weight : ram_rdata.weight + 1'b1;

    assign out_free = !out_valid_reg || code.ready;

    assign sample.ready     = (state_reg == S_IDLE);
    assign code.valid       = out_valid_reg;
    assign code.code_bits   = out_res_reg.code_bits;
    assign code.code_length = out_res_reg.code_length;
    assign code.last        = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        leaf_count_next = leaf_count_reg;
        out_valid_next  = out_valid_reg;
        k_next          = k_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        weight_next     = weight_reg;
        res_next        = res_reg;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = '{group_id: k_reg, weight: weight_reg};
        ram_raddr       = pos_reg;

        if (out_valid_reg && code.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    k_next    = in_k;
                    neg_next  = in_neg;
                    mag_next  = in_mag;
                    last_next = sample.last_sample;
                    if (leaf_count_reg == '0)
                    begin
                        // Empty list: the group is new and goes to the head.
                        res_next        = raw_code(in_neg, in_mag, leaf_count_reg);
                        ram_we          = 1'b1;
                        ram_waddr       = '0;
                        ram_wdata       = '{group_id: in_k, weight: WEIGHT_BITS'(1)};
                        leaf_count_next = leaf_count_reg + 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        pos_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    res_next = known_code(k_reg, neg_reg, mag_reg, pos_reg);
                    if (pos_reg == '0)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = '{group_id: k_reg, weight: hit_weight};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        weight_next = hit_weight;
                        ram_raddr   = pos_reg - 1'b1;
                        state_next  = S_BUBBLE;
                    end
                end
                else if ((CNT_W'(pos_reg) + 1'b1) == leaf_count_reg)
                begin
                    // Searched every listed entry: the group is new.
                    res_next = raw_code(neg_reg, mag_reg, leaf_count_reg);
                    if (leaf_count_reg < CNT_W'(NUM_GROUPS))
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = POS_W'(leaf_count_reg);
                        ram_wdata       = '{group_id: k_reg, weight: WEIGHT_BITS'(1)};
                        leaf_count_next = leaf_count_reg + 1'b1;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    ram_raddr = pos_reg + 1'b1;
                    pos_next  = pos_reg + 1'b1;
                end
            end

            S_BUBBLE:
            begin
                // Read data holds the entry just above the moving one.
                if (ram_rdata.weight < weight_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg == POS_W'(1))
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        ram_raddr = pos_reg - POS_W'(2);
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    state_next = S_OUT;
                end
            end

            S_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_last_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            leaf_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            leaf_count_reg <= leaf_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        weight_reg   <= weight_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire
